@@ src/nnsa_pkg.sv @@
// Shared types and constants of the nearest-neighbor scaler address generator.
`default_nettype none

package nnsa_pkg;

    // Fixed source canvas.
    localparam int SRC_WIDTH  = 720;
    localparam int SRC_HEIGHT = 1280;

    // Coordinate and register widths.
    localparam int DIM_W     = 12;
    localparam int STRIDE_W  = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = STRIDE_W;

    // Quotient and dividend widths of the two scale divisions.
    localparam int COL_QUO_W  = $clog2(SRC_WIDTH);
    localparam int ROW_QUO_W  = $clog2(SRC_HEIGHT);
    localparam int COL_NUM_W  = DIM_W + COL_QUO_W;
    localparam int ROW_NUM_W  = DIM_W + ROW_QUO_W;
    localparam int DIV_STAGES = (COL_QUO_W > ROW_QUO_W) ? COL_QUO_W : ROW_QUO_W;

    localparam int SRC_ADDR_W  = 20;
    localparam int DEST_ADDR_W = 24;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_STRIDE = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [DIM_W-1:0]    RST_DISPLAY_WIDTH  = 12'd720;
    localparam logic [DIM_W-1:0]    RST_DISPLAY_HEIGHT = 12'd1280;
    localparam logic [STRIDE_W-1:0] RST_DISPLAY_STRIDE = 13'd720;

    typedef struct packed {
        logic [DIM_W-1:0] dest_col;
        logic [DIM_W-1:0] dest_row;
    } coord_t;

    typedef struct packed {
        logic [COL_QUO_W-1:0]   source_col;
        logic [ROW_QUO_W-1:0]   source_row;
        logic [SRC_ADDR_W-1:0]  source_addr;
        logic [DEST_ADDR_W-1:0] dest_addr;
        logic                   in_range;
    } result_t;

    // Working set of one beat inside the divider pipeline.
    typedef struct packed {
        logic                   in_range;
        logic [COL_NUM_W-1:0]   col_rem;
        logic [DIM_W-1:0]       col_den;
        logic [COL_QUO_W-1:0]   col_quo;
        logic [ROW_NUM_W-1:0]   row_rem;
        logic [DIM_W-1:0]       row_den;
        logic [ROW_QUO_W-1:0]   row_quo;
        logic [DEST_ADDR_W-1:0] dest_addr;
    } div_lane_t;

endpackage

`default_nettype wire

@@ src/nearest_neighbor_scale_address.sv @@
// Top level of the nearest-neighbor scaler address generator.
// The block takes one destination coordinate per beat and returns the source
// column, source row, linear source address and linear destination address
// for it, with in_range cleared and all addresses zero for a coordinate outside
// the display. It accepts a new coordinate every clock cycle unless a stalled
// result holds the pipeline. The input multiplies are registered, then the
// restoring divider resolves one quotient bit per stage; the source address is
// registered last. When a result is stalled, the whole pipeline holds.
// Configuration is to be written through cfg_we, cfg_index and cfg_data only
// while no beat is in flight; the block itself does not enforce this.
`default_nettype none

module nearest_neighbor_scale_address (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                coord_valid,
    output logic                                     coord_stall,
    input  wire nnsa_pkg::coord_t                    coord,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output nnsa_pkg::result_t                        result,
    input  wire logic                                cfg_we,
    input  wire logic [nnsa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [nnsa_pkg::CFG_W-1:0]          cfg_data
);

    logic [nnsa_pkg::DIM_W-1:0]    width_reg;
    logic [nnsa_pkg::DIM_W-1:0]    height_reg;
    logic [nnsa_pkg::STRIDE_W-1:0] stride_reg;

    logic                advance;
    logic                front_valid_reg;
    nnsa_pkg::div_lane_t front_reg;
    nnsa_pkg::div_lane_t front_next;
    logic                back_valid;
    nnsa_pkg::div_lane_t back;
    logic                result_valid_reg;
    nnsa_pkg::result_t   result_reg;
    nnsa_pkg::result_t   result_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= nnsa_pkg::RST_DISPLAY_WIDTH;
            height_reg <= nnsa_pkg::RST_DISPLAY_HEIGHT;
            stride_reg <= nnsa_pkg::RST_DISPLAY_STRIDE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                nnsa_pkg::REG_DISPLAY_WIDTH:  width_reg  <= cfg_data[nnsa_pkg::DIM_W-1:0];
                nnsa_pkg::REG_DISPLAY_HEIGHT: height_reg <= cfg_data[nnsa_pkg::DIM_W-1:0];
                nnsa_pkg::REG_DISPLAY_STRIDE: stride_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the output register is empty or being taken.
    assign advance     = !result_valid_reg || !result_stall;
    assign coord_stall = !advance;

    always_comb
    begin
        front_next           = '0;
        front_next.in_range  = (coord.dest_col < width_reg) && (coord.dest_row < height_reg);
        front_next.col_rem   = nnsa_pkg::COL_NUM_W'(coord.dest_col)
                               * nnsa_pkg::COL_NUM_W'(nnsa_pkg::SRC_WIDTH);
        front_next.col_den   = width_reg;
        front_next.row_rem   = nnsa_pkg::ROW_NUM_W'(coord.dest_row)
                               * nnsa_pkg::ROW_NUM_W'(nnsa_pkg::SRC_HEIGHT);
        front_next.row_den   = height_reg;
        front_next.dest_addr = nnsa_pkg::DEST_ADDR_W'(coord.dest_row)
                               * nnsa_pkg::DEST_ADDR_W'(stride_reg)
                               + nnsa_pkg::DEST_ADDR_W'(coord.dest_col);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            front_valid_reg  <= coord_valid;
            result_valid_reg <= back_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            front_reg  <= front_next;
            result_reg <= result_next;
        end
    end

    nnsa_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .front_valid (front_valid_reg),
        .front       (front_reg),
        .back_valid  (back_valid),
        .back        (back)
    );

    always_comb
    begin
        result_next = '0;
        if (back.in_range)
        begin
            result_next.source_col  = back.col_quo;
            result_next.source_row  = back.row_quo;
            result_next.source_addr = nnsa_pkg::SRC_ADDR_W'(back.row_quo)
                                      * nnsa_pkg::SRC_ADDR_W'(nnsa_pkg::SRC_WIDTH)
                                      + nnsa_pkg::SRC_ADDR_W'(back.col_quo);
            result_next.dest_addr   = back.dest_addr;
            result_next.in_range    = 1'b1;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A result inside the display always lands on the source canvas.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.in_range |->
            (32'(result.source_col) < nnsa_pkg::SRC_WIDTH)
            && (32'(result.source_row) < nnsa_pkg::SRC_HEIGHT))
        else $error("source coordinate beyond canvas");

    // A held result freezes the divider pipeline behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(back_valid) && $stable(front_valid_reg))
        else $error("pipeline moved under a stalled result");

    // A coordinate outside the display yields no addresses.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.in_range |->
            (result.source_addr == '0) && (result.dest_addr == '0))
        else $error("out-of-range beat carries addresses");

endmodule

`default_nettype wire

@@ src/nnsa_div.sv @@
// Pipelined restoring divider for both scale divisions, one quotient bit per stage.
`default_nettype none

module nnsa_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire logic                front_valid,
    input  wire nnsa_pkg::div_lane_t front,
    output logic                     back_valid,
    output nnsa_pkg::div_lane_t      back
);

    localparam int STAGES = nnsa_pkg::DIV_STAGES;

    logic [STAGES-1:0]   valid_reg;
    nnsa_pkg::div_lane_t stage_reg  [STAGES];
    nnsa_pkg::div_lane_t stage_next [STAGES];
    nnsa_pkg::div_lane_t lane_in    [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        localparam int K = STAGES - 1 - s;

        logic [nnsa_pkg::ROW_NUM_W-1:0] row_sub;
        logic [nnsa_pkg::COL_NUM_W-1:0] col_rem_next;
        logic [nnsa_pkg::COL_QUO_W-1:0] col_quo_next;
        logic [nnsa_pkg::ROW_NUM_W-1:0] row_rem_next;
        logic [nnsa_pkg::ROW_QUO_W-1:0] row_quo_next;

        if (s == 0) begin : g_first
            assign lane_in[s] = front;
        end else begin : g_rest
            assign lane_in[s] = stage_reg[s-1];
        end

        if (K < nnsa_pkg::ROW_QUO_W) begin : g_row
            always_comb
            begin
                row_sub      = nnsa_pkg::ROW_NUM_W'(lane_in[s].row_den) << K;
                row_rem_next = lane_in[s].row_rem;
                row_quo_next = lane_in[s].row_quo;
                if (lane_in[s].row_rem >= row_sub)
                begin
                    row_rem_next    = lane_in[s].row_rem - row_sub;
                    row_quo_next[K] = 1'b1;
                end
            end
        end else begin : g_row_pass
            assign row_sub      = '0;
            assign row_rem_next = lane_in[s].row_rem;
            assign row_quo_next = lane_in[s].row_quo;
        end

        if (K < nnsa_pkg::COL_QUO_W) begin : g_col
            logic [nnsa_pkg::COL_NUM_W-1:0] col_sub;

            always_comb
            begin
                col_sub      = nnsa_pkg::COL_NUM_W'(lane_in[s].col_den) << K;
                col_rem_next = lane_in[s].col_rem;
                col_quo_next = lane_in[s].col_quo;
                if (lane_in[s].col_rem >= col_sub)
                begin
                    col_rem_next    = lane_in[s].col_rem - col_sub;
                    col_quo_next[K] = 1'b1;
                end
            end
        end else begin : g_col_pass
            assign col_rem_next = lane_in[s].col_rem;
            assign col_quo_next = lane_in[s].col_quo;
        end

        always_comb
        begin
            stage_next[s]         = lane_in[s];
            stage_next[s].col_rem = col_rem_next;
            stage_next[s].col_quo = col_quo_next;
            stage_next[s].row_rem = row_rem_next;
            stage_next[s].row_quo = row_quo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], front_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

    assign back_valid = valid_reg[STAGES-1];
    assign back       = stage_reg[STAGES-1];

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the nearest-neighbor scaler address generator.
`default_nettype none

module tb_top;

    localparam logic [nnsa_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int PIPE_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_BEATS    = 275;

    class address_scoreboard;
        logic [nnsa_pkg::DIM_W-1:0]    width_q;
        logic [nnsa_pkg::DIM_W-1:0]    height_q;
        logic [nnsa_pkg::STRIDE_W-1:0] stride_q;
        nnsa_pkg::result_t             expected_q[$];
        int                            errors;

        function new();
            width_q  = nnsa_pkg::RST_DISPLAY_WIDTH;
            height_q = nnsa_pkg::RST_DISPLAY_HEIGHT;
            stride_q = nnsa_pkg::RST_DISPLAY_STRIDE;
            errors   = 0;
        endfunction

        function void set_register(logic [nnsa_pkg::CFG_IDX_W-1:0] reg_index,
                                   logic [nnsa_pkg::CFG_W-1:0] data);
            case (reg_index)
                nnsa_pkg::REG_DISPLAY_WIDTH:  width_q  = data[nnsa_pkg::DIM_W-1:0];
                nnsa_pkg::REG_DISPLAY_HEIGHT: height_q = data[nnsa_pkg::DIM_W-1:0];
                nnsa_pkg::REG_DISPLAY_STRIDE: stride_q = data[nnsa_pkg::STRIDE_W-1:0];
                default: ;
            endcase
        endfunction

        function nnsa_pkg::result_t predict_address(nnsa_pkg::coord_t c);
            nnsa_pkg::result_t r;
            int unsigned       scol;
            int unsigned       srow;
            int unsigned       daddr;
            r = '0;
            if (c.dest_col >= width_q || c.dest_row >= height_q)
            begin
                return r;
            end
            scol  = (int'(c.dest_col) * nnsa_pkg::SRC_WIDTH) / int'(width_q);
            srow  = (int'(c.dest_row) * nnsa_pkg::SRC_HEIGHT) / int'(height_q);
            daddr = int'(c.dest_row) * int'(stride_q) + int'(c.dest_col);
            r.source_col  = nnsa_pkg::COL_QUO_W'(scol);
            r.source_row  = nnsa_pkg::ROW_QUO_W'(srow);
            r.source_addr = nnsa_pkg::SRC_ADDR_W'(srow * nnsa_pkg::SRC_WIDTH + scol);
            r.dest_addr   = nnsa_pkg::DEST_ADDR_W'(daddr);
            r.in_range    = 1'b1;
            return r;
        endfunction

        function void note_coord(nnsa_pkg::coord_t c);
            expected_q.push_back(predict_address(c));
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(nnsa_pkg::result_t got);
            nnsa_pkg::result_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result beat %h arrived with nothing expected", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("source_col", 32'(want.source_col), 32'(got.source_col));
            compare_field("source_row", 32'(want.source_row), 32'(got.source_row));
            compare_field("source_addr", 32'(want.source_addr), 32'(got.source_addr));
            compare_field("dest_addr", 32'(want.dest_addr), 32'(got.dest_addr));
            compare_field("in_range", 32'(want.in_range), 32'(got.in_range));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           coord_valid;
    logic                           coord_stall;
    nnsa_pkg::coord_t               coord;
    logic                           result_valid;
    logic                           result_stall;
    nnsa_pkg::result_t              result;
    logic                           cfg_we;
    logic [nnsa_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [nnsa_pkg::CFG_W-1:0]     cfg_data;

    address_scoreboard sb = new();
    bit                send_idling = 1'b0;
    int                idle_cycles = 0;

    nearest_neighbor_scale_address u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .coord_valid  (coord_valid),
        .coord_stall  (coord_stall),
        .coord        (coord),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (coord_valid && !coord_stall) || (result_valid && !result_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic nnsa_pkg::coord_t make_coord(int col, int row);
        nnsa_pkg::coord_t c;
        c.dest_col = nnsa_pkg::DIM_W'(col);
        c.dest_row = nnsa_pkg::DIM_W'(row);
        return c;
    endfunction

    function automatic logic [nnsa_pkg::DIM_W-1:0] pick_axis(
        logic [nnsa_pkg::DIM_W-1:0] limit);
        int roll;
        roll = $urandom_range(0, 9);
        if (limit == 0 || roll < 2)
        begin
            return nnsa_pkg::DIM_W'($urandom);
        end
        if (roll == 2)
        begin
            return limit - 1'b1;
        end
        if (roll == 3)
        begin
            return limit;
        end
        return nnsa_pkg::DIM_W'($urandom_range(0, int'(limit) - 1));
    endfunction

    function automatic nnsa_pkg::coord_t random_coord();
        nnsa_pkg::coord_t c;
        c.dest_col = pick_axis(sb.width_q);
        c.dest_row = pick_axis(sb.height_q);
        return c;
    endfunction

    function automatic logic [nnsa_pkg::CFG_W-1:0] random_dimension(int usual);
        logic [nnsa_pkg::DIM_W-1:0] dim;
        case ($urandom_range(0, 5))
            0:       dim = 12'd1;
            1:       dim = 12'd4095;
            2:       dim = nnsa_pkg::DIM_W'(usual);
            default: dim = nnsa_pkg::DIM_W'($urandom_range(1, 4095));
        endcase
        return {1'($urandom_range(0, 1)), dim};
    endfunction

    function automatic logic [nnsa_pkg::CFG_W-1:0] random_stride(
        logic [nnsa_pkg::DIM_W-1:0] width);
        case ($urandom_range(0, 4))
            0:       return nnsa_pkg::CFG_W'(width);
            1:       return '0;
            2:       return 13'd8191;
            default: return nnsa_pkg::CFG_W'($urandom_range(0, 8191));
        endcase
    endfunction

    task automatic send_coord(nnsa_pkg::coord_t c);
        int gap;
        gap = send_idling ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            coord_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        coord_valid <= 1'b1;
        coord       <= c;
        do @(posedge clk); while (coord_stall);
        sb.note_coord(c);
        @(negedge clk);
    endtask

    task automatic drain_pipeline();
        coord_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (PIPE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [nnsa_pkg::CFG_IDX_W-1:0] reg_index,
                             logic [nnsa_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= data;
        sb.set_register(reg_index, data);
        @(negedge clk);
    endtask

    task automatic configure(logic [nnsa_pkg::CFG_W-1:0] width,
                             logic [nnsa_pkg::CFG_W-1:0] height,
                             logic [nnsa_pkg::CFG_W-1:0] stride, bit poke_spare);
        write_reg(nnsa_pkg::REG_DISPLAY_WIDTH, width);
        write_reg(nnsa_pkg::REG_DISPLAY_HEIGHT, height);
        write_reg(nnsa_pkg::REG_DISPLAY_STRIDE, stride);
        if (poke_spare)
        begin
            write_reg(REG_SPARE, nnsa_pkg::CFG_W'($urandom));
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin : result_sink
        int stall_cycles;
        bit stalling;
        int beats;
        stalling = 1'b0;
        beats    = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (beats % 64 == 0)
            begin
                stalling = 1'($urandom_range(0, 1));
            end
            stall_cycles = stalling ? $urandom_range(0, 8) : 0;
            if (stall_cycles > 0)
            begin
                result_stall <= 1'b1;
                repeat (stall_cycles) @(negedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
            sb.check_result(result);
            beats++;
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int                         phase;
        int                         beat;
        logic [nnsa_pkg::CFG_W-1:0] width;
        rst_n        = 1'b0;
        coord_valid  = 1'b0;
        coord        = '0;
        result_stall = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = nnsa_pkg::REG_DISPLAY_WIDTH;
        cfg_data     = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The reset geometry maps the canvas onto itself.
        send_coord(make_coord(0, 0));
        send_coord(make_coord(719, 1279));
        send_coord(make_coord(720, 0));
        send_coord(make_coord(0, 1280));
        send_coord(make_coord(360, 640));
        send_coord(make_coord(4095, 4095));

        // The largest display with the widest stride wraps the destination address.
        drain_pipeline();
        configure(13'd4095, 13'd4095, 13'd8191, 1'b0);
        send_coord(make_coord(4094, 4094));
        send_coord(make_coord(4095, 0));
        send_coord(make_coord(0, 4095));
        send_coord(make_coord(2048, 1));

        drain_pipeline();
        configure(13'd1, 13'd1, 13'd0, 1'b0);
        send_coord(make_coord(0, 0));
        send_coord(make_coord(1, 0));
        send_coord(make_coord(0, 1));

        // A zero width or height puts every coordinate outside the display.
        drain_pipeline();
        configure(13'd0, 13'd7, 13'd3, 1'b1);
        send_coord(make_coord(0, 0));
        send_coord(make_coord(5, 3));

        drain_pipeline();
        configure(13'd9, 13'd0, 13'd4096, 1'b0);
        send_coord(make_coord(3, 0));

        drain_pipeline();
        configure(13'd720, 13'd1280, 13'd100, 1'b0);
        send_coord(make_coord(719, 1279));
        send_coord(make_coord(1, 2));

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_pipeline();
            if (phase == 0)
            begin
                configure(13'd4095, 13'd4095, 13'd8191, 1'b1);
            end
            else
            begin
                width = random_dimension(nnsa_pkg::SRC_WIDTH);
                configure(width, random_dimension(nnsa_pkg::SRC_HEIGHT),
                          random_stride(width[nnsa_pkg::DIM_W-1:0]),
                          1'($urandom_range(0, 1)));
            end
            for (beat = 0; beat < PHASE_BEATS; beat++)
            begin
                if (beat % 50 == 0)
                begin
                    send_idling = 1'($urandom_range(0, 1));
                end
                send_coord(random_coord());
            end
        end

        drain_pipeline();
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
src/nnsa_pkg.sv
src/nnsa_div.sv
src/nearest_neighbor_scale_address.sv
test/tb_top.sv
